@@ hw/rtl/fhpr_pkg.sv @@
// ----------------------------------------------------------------------------
// fhpr_pkg
// Shared types and constants for the frame header / payload receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package fhpr_pkg;

    localparam int unsigned STORE_DEPTH = 256;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
    localparam logic [15:0] LENGTH_BIAS = 16'd4;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_STORED = 2'd1,
        EV_DONE   = 2'd2
    } t_event_kind;

    // position of a byte within the eight byte header
    typedef enum logic [2:0] {
        HDR_TYPE    = 3'd0,
        HDR_FLAGS   = 3'd1,
        HDR_LEN_LO  = 3'd2,
        HDR_LEN_HI  = 3'd3,
        HDR_HCRC_LO = 3'd4,
        HDR_HCRC_HI = 3'd5,
        HDR_PCRC_LO = 3'd6,
        HDR_PCRC_HI = 3'd7
    } t_hdr_pos;

    typedef struct packed {
        t_event_kind event_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        process_request;
        logic        comm_detected;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [15:0] body_length;
        logic [15:0] header_crc;
        logic [15:0] payload_crc;
    } t_event;

endpackage

`default_nettype wire

@@ hw/rtl/fhpr_rx_if.sv @@
// ----------------------------------------------------------------------------
// fhpr_rx_if
// Valid/ready channel carrying one received byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fhpr_ev_if.sv @@
// ----------------------------------------------------------------------------
// fhpr_ev_if
// Valid/ready channel carrying one receiver event word per byte taken.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhpr_ev_if
    import fhpr_pkg::*;
;
    logic        valid;
    logic        ready;
    t_event_kind event_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        process_request;
    logic        comm_detected;
    logic [7:0]  msg_type;
    logic [7:0]  msg_flags;
    logic [15:0] body_length;
    logic [15:0] header_crc;
    logic [15:0] payload_crc;

    modport source (
        output valid, input ready,
        output event_kind, output payload_byte, output payload_index,
        output process_request, output comm_detected,
        output msg_type, output msg_flags, output body_length,
        output header_crc, output payload_crc
    );
    modport sink (
        input valid, output ready,
        input event_kind, input payload_byte, input payload_index,
        input process_request, input comm_detected,
        input msg_type, input msg_flags, input body_length,
        input header_crc, input payload_crc
    );
endinterface

`default_nettype wire

@@ hw/rtl/frame_header_payload_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// frame_header_payload_receiver_unit
// Byte-wise frame receiver: eight header bytes, then payload until length.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            word
//  i_rx      in    valid / ready        rx_byte
//  o_ev      out   valid / ready        event kind, payload byte/index, flags,
//                                       header fields after the byte
//  cfg       in    i_cfg_we             i_cfg_wdata = initializing mode
//
//  one byte taken per cycle unless stalled; its event word appears next cycle
//  the single result register sets the pace: a new byte is taken while the
//  held word is drained, and only a stalled full register holds i_rx off
//  synchronous active-low reset clears the frame state and header fields
// ----------------------------------------------------------------------------
`default_nettype none

module frame_header_payload_receiver_unit
    import fhpr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_wdata,
    fhpr_rx_if.sink   i_rx,
    fhpr_ev_if.source o_ev
);

    logic   r_init_mode;
    logic   can_load;
    logic   take;
    t_event core_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_init_mode <= i_cfg_wdata;
        end
    end

    assign i_rx.ready = can_load;
    assign take       = i_rx.valid && can_load;

    fhpr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_rx_byte   (i_rx.rx_byte),
        .i_init_mode (r_init_mode),
        .o_event     (core_event)
    );

    fhpr_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_event    (core_event),
        .o_can_load (can_load),
        .o_ev       (o_ev)
    );

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev.valid |-> !(o_ev.process_request && o_ev.comm_detected))
        else $error("process request and comm detected both set");

    a_flags_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ev.valid |-> ((o_ev.process_request || o_ev.comm_detected)
                        == (o_ev.event_kind == EV_DONE)))
        else $error("completion flag does not match event kind");

    a_header_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.valid && (o_ev.event_kind == EV_HEADER)) |->
            ((o_ev.payload_byte == 8'd0) && (o_ev.payload_index == 8'd0)))
        else $error("header word carries payload data");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.valid && !o_ev.ready) |-> !i_rx.ready)
        else $error("byte taken while result register is stalled");

endmodule

`default_nettype wire

@@ hw/rtl/fhpr_core.sv @@
// ----------------------------------------------------------------------------
// fhpr_core
// Frame state: header capture, payload write index and completion check.
// ----------------------------------------------------------------------------
`default_nettype none

module fhpr_core
    import fhpr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_take,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic   i_init_mode,
    output t_event      o_event
);

    logic             r_in_body,   n_in_body;
    t_hdr_pos         r_hdr_pos,   n_hdr_pos;
    logic [7:0]       r_type,      n_type;
    logic [7:0]       r_flags,     n_flags;
    logic [15:0]      r_length,    n_length;
    logic [15:0]      r_hcrc,      n_hcrc;
    logic [15:0]      r_pcrc,      n_pcrc;
    logic [IDX_W-1:0] r_body_idx,  n_body_idx;

    logic [IDX_W-1:0] idx_next;
    logic [15:0]      idx_next16;
    logic [15:0]      pos16;
    logic             done;

    always_comb begin
        // write index wraps at the store depth
        if (r_body_idx == IDX_W'(STORE_DEPTH - 1)) begin
            idx_next = '0;
        end else begin
            idx_next = r_body_idx + IDX_W'(1);
        end
        idx_next16 = 16'(idx_next);
        pos16      = 16'(r_body_idx);
        // odd lengths take one pad byte
        done = (idx_next16 > r_length) ||
               ((idx_next16 == r_length) && !r_length[0]);
    end

    always_comb begin
        n_in_body  = r_in_body;
        n_hdr_pos  = r_hdr_pos;
        n_type     = r_type;
        n_flags    = r_flags;
        n_length   = r_length;
        n_hcrc     = r_hcrc;
        n_pcrc     = r_pcrc;
        n_body_idx = r_body_idx;

        o_event.event_kind      = EV_HEADER;
        o_event.payload_byte    = 8'd0;
        o_event.payload_index   = 8'd0;
        o_event.process_request = 1'b0;
        o_event.comm_detected   = 1'b0;

        if (!r_in_body) begin
            n_hdr_pos = t_hdr_pos'(r_hdr_pos + 3'd1);
            unique case (r_hdr_pos)
                HDR_TYPE:    n_type   = i_rx_byte;
                HDR_FLAGS:   n_flags  = i_rx_byte;
                HDR_LEN_LO:  n_length = {8'd0, i_rx_byte};
                HDR_LEN_HI:  n_length = {i_rx_byte, r_length[7:0]} - LENGTH_BIAS;
                HDR_HCRC_LO: n_hcrc   = {8'd0, i_rx_byte};
                HDR_HCRC_HI: n_hcrc   = {i_rx_byte, r_hcrc[7:0]};
                HDR_PCRC_LO: n_pcrc   = {8'd0, i_rx_byte};
                HDR_PCRC_HI: begin
                    n_pcrc     = {i_rx_byte, r_pcrc[7:0]};
                    n_in_body  = 1'b1;
                    n_body_idx = '0;
                end
                default: n_type = r_type;
            endcase
        end else begin
            o_event.event_kind    = EV_STORED;
            o_event.payload_byte  = i_rx_byte;
            o_event.payload_index = pos16[7:0];
            n_body_idx            = idx_next;
            if (done) begin
                o_event.event_kind      = EV_DONE;
                o_event.process_request = i_init_mode;
                o_event.comm_detected   = !i_init_mode;
                n_in_body               = 1'b0;
                n_hdr_pos               = HDR_TYPE;
                n_body_idx              = '0;
            end
        end

        // header fields as they stand after this byte
        o_event.msg_type    = n_type;
        o_event.msg_flags   = n_flags;
        o_event.body_length = n_length;
        o_event.header_crc  = n_hcrc;
        o_event.payload_crc = n_pcrc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body  <= 1'b0;
            r_hdr_pos  <= HDR_TYPE;
            r_type     <= 8'd0;
            r_flags    <= 8'd0;
            r_length   <= 16'd0;
            r_hcrc     <= 16'd0;
            r_pcrc     <= 16'd0;
            r_body_idx <= '0;
        end else if (i_take) begin
            r_in_body  <= n_in_body;
            r_hdr_pos  <= n_hdr_pos;
            r_type     <= n_type;
            r_flags    <= n_flags;
            r_length   <= n_length;
            r_hcrc     <= n_hcrc;
            r_pcrc     <= n_pcrc;
            r_body_idx <= n_body_idx;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fhpr_out_reg.sv @@
// ----------------------------------------------------------------------------
// fhpr_out_reg
// Result register driving the event channel; refills while being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module fhpr_out_reg
    import fhpr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_event  i_event,
    output logic         o_can_load,
    fhpr_ev_if.source    o_ev
);

    logic   r_valid, n_valid;
    t_event r_event;

    assign o_can_load = !r_valid || o_ev.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_ev.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_event <= i_event;
        end
    end

    assign o_ev.valid           = r_valid;
    assign o_ev.event_kind      = r_event.event_kind;
    assign o_ev.payload_byte    = r_event.payload_byte;
    assign o_ev.payload_index   = r_event.payload_index;
    assign o_ev.process_request = r_event.process_request;
    assign o_ev.comm_detected   = r_event.comm_detected;
    assign o_ev.msg_type        = r_event.msg_type;
    assign o_ev.msg_flags       = r_event.msg_flags;
    assign o_ev.body_length     = r_event.body_length;
    assign o_ev.header_crc      = r_event.header_crc;
    assign o_ev.payload_crc     = r_event.payload_crc;

endmodule

`default_nettype wire

@@ verif/frame_header_payload_receiver_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_header_payload_receiver_unit_tb
// Feeds received bytes as whole frames (eight byte header, then payload) and
// checks every event word against a cycle-free model of the frame state, under
// random idling on both channels and with the initializing mode set and clear.
// ----------------------------------------------------------------------------
module frame_header_payload_receiver_unit_tb;
    import fhpr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_WORDS  = 480;
    localparam int unsigned TAIL_BYTES   = 300;

    typedef struct {
        logic [7:0] rx_byte;
        bit         typed;
        t_event     word;
    } t_rx_plan;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    fhpr_rx_if rx_if();
    fhpr_ev_if ev_if();

    frame_header_payload_receiver_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_ev        (ev_if)
    );

    // model of the frame state
    bit          init_mode;
    bit          in_body;
    t_hdr_pos    hdr_pos;
    logic [7:0]  type_q;
    logic [7:0]  flags_q;
    logic [15:0] len_q;
    logic [15:0] hcrc_q;
    logic [15:0] pcrc_q;
    int unsigned body_pos;

    t_event      expected_events[$];
    t_rx_plan    rx_plan[$];
    t_rx_plan    dir_table[$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned bytes_sent;
    int unsigned words_checked;
    int unsigned frames_req;
    int unsigned frames_comm;
    int unsigned mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d words still expected",
                 cycles, expected_events.size());
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        ev_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic t_event frame_rx_predict(input logic [7:0] b);
        t_event      e;
        int unsigned nxt;
        e = '0;
        if (!in_body) begin
            case (hdr_pos)
                HDR_TYPE:    type_q  = b;
                HDR_FLAGS:   flags_q = b;
                HDR_LEN_LO:  len_q   = {8'h00, b};
                HDR_LEN_HI:  len_q   = {b, len_q[7:0]} - LENGTH_BIAS;
                HDR_HCRC_LO: hcrc_q  = {8'h00, b};
                HDR_HCRC_HI: hcrc_q  = {b, hcrc_q[7:0]};
                HDR_PCRC_LO: pcrc_q  = {8'h00, b};
                default: begin
                    pcrc_q   = {b, pcrc_q[7:0]};
                    in_body  = 1'b1;
                    body_pos = 0;
                end
            endcase
            hdr_pos = t_hdr_pos'(hdr_pos + 3'd1);
            e.event_kind = EV_HEADER;
        end else begin
            e.payload_byte  = b;
            e.payload_index = body_pos[7:0];
            nxt = body_pos + 1;
            if (nxt >= STORE_DEPTH) begin
                nxt = 0;
            end
            body_pos = nxt;
            e.event_kind = EV_STORED;
            // odd lengths need one pad byte past the length
            if (nxt > len_q || (nxt == len_q && !len_q[0])) begin
                e.event_kind      = EV_DONE;
                e.process_request = init_mode;
                e.comm_detected   = !init_mode;
                in_body  = 1'b0;
                hdr_pos  = HDR_TYPE;
                body_pos = 0;
                if (init_mode) begin
                    frames_req++;
                end else begin
                    frames_comm++;
                end
            end
        end
        e.msg_type    = type_q;
        e.msg_flags   = flags_q;
        e.body_length = len_q;
        e.header_crc  = hcrc_q;
        e.payload_crc = pcrc_q;
        return e;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_event(input t_event want, input t_event got);
        if (got.event_kind !== want.event_kind)
            report_mismatch("event_kind", got.event_kind, want.event_kind);
        if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
        if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", got.payload_index, want.payload_index);
        if (got.process_request !== want.process_request)
            report_mismatch("process_request", got.process_request, want.process_request);
        if (got.comm_detected !== want.comm_detected)
            report_mismatch("comm_detected", got.comm_detected, want.comm_detected);
        if (got.msg_type !== want.msg_type)
            report_mismatch("msg_type", got.msg_type, want.msg_type);
        if (got.msg_flags !== want.msg_flags)
            report_mismatch("msg_flags", got.msg_flags, want.msg_flags);
        if (got.body_length !== want.body_length)
            report_mismatch("body_length", got.body_length, want.body_length);
        if (got.header_crc !== want.header_crc)
            report_mismatch("header_crc", got.header_crc, want.header_crc);
        if (got.payload_crc !== want.payload_crc)
            report_mismatch("payload_crc", got.payload_crc, want.payload_crc);
    endtask

    // predict on every byte taken, check every event word drained
    always @(posedge i_clk) begin : monitor
        t_rx_plan plan;
        t_event   predicted;
        t_event   got;
        if (i_rst_n) begin
            if (rx_if.valid && rx_if.ready) begin
                plan = rx_plan.pop_front();
                predicted = frame_rx_predict(rx_if.rx_byte);
                expected_events.push_back(plan.typed ? plan.word : predicted);
            end
            if (ev_if.valid && ev_if.ready) begin
                got = t_event'{ev_if.event_kind, ev_if.payload_byte, ev_if.payload_index,
                               ev_if.process_request, ev_if.comm_detected,
                               ev_if.msg_type, ev_if.msg_flags, ev_if.body_length,
                               ev_if.header_crc, ev_if.payload_crc};
                if (expected_events.size() == 0) begin
                    report_mismatch("word with none expected", got.event_kind, 0);
                end else begin
                    check_event(expected_events.pop_front(), got);
                end
                words_checked++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input t_event want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_plan.push_back('{b, typed, want});
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    // stuck_len: length field below four, the frame never completes
    task automatic send_frame(input bit stuck_len);
        logic [15:0] raw_len;
        logic [15:0] body_len;
        logic [15:0] hcrc;
        logic [15:0] pcrc;
        int unsigned n_body;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (stuck_len) begin
            raw_len = 16'($urandom_range(0, 3));
        end else if (pick < 80) begin
            raw_len = 16'(4 + $urandom_range(0, 24));
        end else if (pick < 95) begin
            raw_len = 16'(4 + $urandom_range(25, 120));
        end else begin
            raw_len = 16'(4 + $urandom_range(200, 254));
        end
        body_len = raw_len - LENGTH_BIAS;
        hcrc = 16'($urandom);
        pcrc = 16'($urandom);
        if (stuck_len) begin
            n_body = TAIL_BYTES;
        end else if (body_len == 0) begin
            n_body = 1;
        end else begin
            n_body = body_len + body_len[0];
        end
        send_byte(8'($urandom), 1'b0, '0);
        send_byte(8'($urandom), 1'b0, '0);
        send_byte(raw_len[7:0], 1'b0, '0);
        send_byte(raw_len[15:8], 1'b0, '0);
        send_byte(hcrc[7:0], 1'b0, '0);
        send_byte(hcrc[15:8], 1'b0, '0);
        send_byte(pcrc[7:0], 1'b0, '0);
        send_byte(pcrc[15:8], 1'b0, '0);
        repeat (n_body) send_byte(8'($urandom), 1'b0, '0);
    endtask

    task automatic set_mode(input bit m);
        rx_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        init_mode = m;
    endtask

    task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit m);
        int unsigned goal;
        set_mode(m);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        goal = bytes_sent + PHASE_WORDS;
        while (bytes_sent < goal) send_frame(1'b0);
    endtask

    initial begin
        init_mode      = 1'b0;
        in_body        = 1'b0;
        hdr_pos        = HDR_TYPE;
        type_q         = '0;
        flags_q        = '0;
        len_q          = '0;
        hcrc_q         = '0;
        pcrc_q         = '0;
        body_pos       = 0;
        tx_idle_pct    = 36;
        rx_idle_pct    = 74;
        bytes_sent     = 0;
        words_checked  = 0;
        frames_req     = 0;
        frames_comm    = 0;
        mismatch_count = 0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;

        // length 0 frame, all-ones type and header crc: first word shows the new type over reset header state
        dir_table.push_back('{8'hFF, 1'b1, t_event'{EV_HEADER, 8'h00, 8'h00, 1'b0, 1'b0,
                               8'hFF, 8'h00, 16'h0000, 16'h0000, 16'h0000}});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'h04, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b1, t_event'{EV_DONE, 8'hFF, 8'h00, 1'b0, 1'b1,
                               8'hFF, 8'h00, 16'h0000, 16'hFFFF, 16'h0000}});
        // length 1 frame: one data byte, then the pad byte completes it
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b0, '0});
        dir_table.push_back('{8'h05, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'h00, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b0, '0});
        dir_table.push_back('{8'hFF, 1'b0, '0});
        dir_table.push_back('{8'hA5, 1'b0, '0});
        dir_table.push_back('{8'h5A, 1'b1, t_event'{EV_DONE, 8'h5A, 8'h01, 1'b0, 1'b1,
                               8'h00, 8'hFF, 16'h0001, 16'h0000, 16'hFFFF}});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(1'b0);
        foreach (dir_table[i]) begin
            send_byte(dir_table[i].rx_byte, dir_table[i].typed, dir_table[i].word);
        end

        run_phase(36, 74, 1'b1);
        run_phase(74, 36, 1'b0);
        run_phase(0, 0, 1'b1);
        // short length field wraps the stored length: the write index runs
        // around the store and no completion ever comes
        send_frame(1'b1);

        rx_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes sent, %0d event words checked", bytes_sent, words_checked);
        $display("frames completed: %0d with process request, %0d with comm detected",
                 frames_req, frames_comm);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
